[src/cdtd_pkg.sv]
// Shared constants and types for the color difference threshold and dilate block.
package cdtd_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int PIXEL_BITS_DEF = 8;

   localparam int SIZE_BITS  = 12;
   localparam int THR_BITS   = 8;
   localparam int CSR_BITS   = 12;
   localparam int ROW_BITS   = 12;
   localparam int MAX_HEIGHT = 2048;

   localparam logic                 COLOR_MODE_RST = 1'b0;
   localparam logic [THR_BITS-1:0]  THRESHOLD_RST  = 8'd100;
   localparam logic [SIZE_BITS-1:0] WIDTH_RST      = 12'd1280;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RST     = 12'd1024;

   typedef enum logic [1:0] {
      CSR_COLOR_MODE   = 2'd0,
      CSR_THRESHOLD    = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_FRAME_HEIGHT = 2'd3
   } csr_index_type;

   // Per word control carried from the read stage to the window stage.
   typedef struct packed {
      logic emit;
      logic col_zero;
      logic up_ok;
      logic down_ok;
      logic left_ok;
      logic right_ok;
      logic row_end;
      logic frame_end;
      logic mark;
   } win_ctl_type;

endpackage

[src/color_diff_threshold_dilate.sv]
// Color difference binarizer with plus-shaped 3x3 dilation over a raster pixel stream.
//
// Pixels enter on the req_ channel in raster order, one word per cycle when both sides
// keep up. frame_start marks the first pixel; req_func=1 is a pad word that counts as an
// unmarked pixel. After the last pixel of a frame, frame_width+1 pad words flush the
// final row. Dilated mask bits leave on the rsp_ channel with row_end and frame_end.
// A result is produced by the word that arrives one row and one pixel after its pixel.
// Pipeline: the accepting edge reads the combined line store (a single-port-per-side RAM
// with a registered read) into the window stage; when the output register is free, that
// stage shifts the 3x3 window and forms the result into the output register.
// Throughput is one word per cycle while the output keeps up; the line store is read for
// one word while the word ahead writes back, and a same-column overlap is forwarded
// around the RAM. When a result waits with rsp_ready low the output register holds and
// the window stage backs up; req_ready drops only when the window stage cannot move.
// Reset clears the counters, the pipeline and the registers to their defaults; the line store
// is not cleared; entries read before the first row of a frame writes them are masked out.
// csr_ writes take effect at once and are meant for idle periods between frames.
module color_diff_threshold_dilate #(
   parameter int MAX_WIDTH  = cdtd_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = cdtd_pkg::PIXEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [PIXEL_BITS-1:0]         req_blue_level,
   input  logic [PIXEL_BITS-1:0]         req_red_level,
   input  logic                          req_frame_start,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_mask,
   output logic                          rsp_row_end,
   output logic                          rsp_frame_end,

   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [cdtd_pkg::CSR_BITS-1:0] csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = cdtd_pkg::ROW_BITS;

   // configuration
   logic                            color_mode_ff;
   logic [cdtd_pkg::THR_BITS-1:0]   threshold_ff;
   logic [cdtd_pkg::SIZE_BITS-1:0]  frame_width_ff;
   logic [cdtd_pkg::SIZE_BITS-1:0]  frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff   <= cdtd_pkg::COLOR_MODE_RST;
         threshold_ff    <= cdtd_pkg::THRESHOLD_RST;
         frame_width_ff  <= cdtd_pkg::WIDTH_RST;
         frame_height_ff <= cdtd_pkg::HEIGHT_RST;
      end else if (csr_we) begin
         unique case (cdtd_pkg::csr_index_type'(csr_index))
            cdtd_pkg::CSR_COLOR_MODE:   color_mode_ff   <= csr_wdata[0];
            cdtd_pkg::CSR_THRESHOLD:    threshold_ff    <= csr_wdata[cdtd_pkg::THR_BITS-1:0];
            cdtd_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[cdtd_pkg::SIZE_BITS-1:0];
            cdtd_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[cdtd_pkg::SIZE_BITS-1:0];
         endcase
      end
   end

   // clamped frame size
   logic [WW-1:0] width_eff;
   logic [RW-1:0] height_eff;
   logic [RW:0]   height_p1;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = RW'(1);
      end else if (32'(frame_height_ff) > cdtd_pkg::MAX_HEIGHT) begin
         height_eff = RW'(cdtd_pkg::MAX_HEIGHT);
      end else begin
         height_eff = RW'(frame_height_ff);
      end
      height_p1 = {1'b0, height_eff} + 1'b1;
   end

   // handshake between stages
   logic                  s1_valid_ff;
   logic                  out_free;
   logic                  s1_fire;
   logic                  accept;
   logic                  rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // input position
   logic [CW-1:0] in_column_ff, in_column_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] col0, col1;
   logic [RW-1:0] row0, row1;
   logic [WW:0]   col_next;
   logic          done;

   always_comb begin
      col0 = req_frame_start ? '0 : in_column_ff;
      row0 = req_frame_start ? '0 : in_row_ff;
      // a column past a narrowed width wraps to the next row; saturate the row
      if (WW'(col0) >= width_eff) begin
         col1 = '0;
         row1 = (row0 == '1) ? row0 : row0 + 1'b1;
      end else begin
         col1 = col0;
         row1 = row0;
      end
      done = ({1'b0, row1} > height_p1) || ({1'b0, row1} == height_p1 && col1 != '0);

      col_next = {1'b0, WW'(col1)} + 1'b1;
      if (done) begin
         in_column_in = col1;
         in_row_in    = row1;
      end else if (col_next >= {1'b0, width_eff}) begin
         in_column_in = '0;
         in_row_in    = row1 + 1'b1;
      end else begin
         in_column_in = CW'(col_next);
         in_row_in    = row1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
      end else if (accept) begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
      end
   end

   // threshold the color difference
   logic [PIXEL_BITS-1:0] level_a, level_b, level_diff;
   logic                  mark;

   always_comb begin
      level_a    = color_mode_ff ? req_red_level : req_blue_level;
      level_b    = color_mode_ff ? req_blue_level : req_red_level;
      level_diff = (level_a > level_b) ? level_a - level_b : '0;
      mark = !req_func && (row1 < height_eff) &&
             (level_diff > PIXEL_BITS'(threshold_ff));
   end

   // neighbor masks for the result this word produces
   cdtd_pkg::win_ctl_type ctl_in;
   logic [RW:0]           row1_x;

   always_comb begin
      row1_x = {1'b0, row1};
      ctl_in = '0;
      ctl_in.mark     = mark;
      ctl_in.col_zero = (col1 == '0);
      if (col1 == '0) begin
         // last pixel of the row two back
         ctl_in.emit      = (row1 >= RW'(2)) && (row1_x < height_p1 + 1'b1);
         ctl_in.up_ok     = (row1 >= RW'(3));
         ctl_in.down_ok   = (row1_x < height_p1);
         ctl_in.left_ok   = (width_eff > WW'(1));
         ctl_in.right_ok  = 1'b0;
         ctl_in.row_end   = 1'b1;
         ctl_in.frame_end = (row1_x == height_p1);
      end else begin
         ctl_in.emit      = (row1 >= RW'(1)) && (row1_x < height_p1);
         ctl_in.up_ok     = (row1 >= RW'(2));
         ctl_in.down_ok   = (row1 < height_eff);
         ctl_in.left_ok   = (col1 >= CW'(2));
         ctl_in.right_ok  = 1'b1;
         ctl_in.row_end   = 1'b0;
         ctl_in.frame_end = 1'b0;
      end
   end

   // line store: bit 1 holds the previous row, bit 0 the row before it
   logic [1:0]            line_mem [MAX_WIDTH];
   logic [1:0]            line_rd_ff;
   logic [1:0]            fwd_data_ff;
   logic                  fwd_hit_ff;
   logic [CW-1:0]         s1_col_ff;
   cdtd_pkg::win_ctl_type s1_ctl_ff;
   logic [1:0]            line_word;
   logic                  s1_prev, s1_older;

   assign line_word = fwd_hit_ff ? fwd_data_ff : line_rd_ff;
   assign s1_prev   = line_word[1];
   assign s1_older  = line_word[0];

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         line_mem[s1_col_ff] <= {s1_ctl_ff.mark, s1_prev};
      end
      if (accept) begin
         line_rd_ff <= line_mem[col1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= {s1_ctl_ff.mark, s1_prev};
         s1_col_ff   <= col1;
         s1_ctl_ff   <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (accept) begin
         // the word ahead writes the column being read: take its data
         fwd_hit_ff  <= s1_fire && (s1_col_ff == col1);
         s1_valid_ff <= !done;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // 3x3 window: [8:6] center column, [5:3] left, [2:0] one older; bit order up, mid, down
   logic [8:0] window_ff, window_in;
   logic [2:0] new_column;
   logic       dilated;

   always_comb begin
      new_column = {s1_ctl_ff.mark, s1_prev, s1_older};
      window_in  = s1_ctl_ff.col_zero ? {new_column, 6'b0} : {new_column, window_ff[8:3]};
      // center sits in the newest stored column, left one column older
      dilated = window_ff[7]
              | (s1_ctl_ff.up_ok    & window_ff[6])
              | (s1_ctl_ff.down_ok  & window_ff[8])
              | (s1_ctl_ff.left_ok  & window_ff[4])
              | (s1_ctl_ff.right_ok & s1_prev);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_fire) begin
         window_ff <= window_in;
      end
   end

   // output register
   logic rsp_mask_ff, rsp_row_end_ff, rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_ctl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ctl_ff.emit) begin
         rsp_mask_ff      <= dilated;
         rsp_row_end_ff   <= s1_ctl_ff.row_end;
         rsp_frame_end_ff <= s1_ctl_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mask      = rsp_mask_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // checks
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_ready)
      else $error("word accepted while window stage is stalled");

   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_ctl_ff.emit) |=> rsp_valid)
      else $error("result from window stage lost");

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_row_end)
      else $error("frame end outside a row end");

   a_forward_only_on_overlap: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_fire && s1_col_ff == col1) |=> fwd_hit_ff)
      else $error("same column overlap not forwarded");

endmodule
